// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define JSU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/jsu_pkg.sv -----
// Package: types and character codes of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int unsigned JSU_MAX_OUT = 3;
  localparam int unsigned JSU_CNT_W   = 2;

  // Escape state: plain text, after a backslash, or waiting for hex byte 1..4.
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX1  = 3'd2,
    MODE_HEX2  = 3'd3,
    MODE_HEX3  = 3'd4,
    MODE_HEX4  = 3'd5
  } jsu_mode_t;

  typedef struct packed {
    jsu_mode_t   mode;
    logic [15:0] hex_value;
    logic        hex_ended;
    logic        quoted;
  } jsu_state_t;

  localparam jsu_state_t JSU_STATE_RST = '{
    mode:      MODE_PLAIN,
    hex_value: 16'h0000,
    hex_ended: 1'b0,
    quoted:    1'b0
  };

  // Result bytes of one input byte, lead byte in entry 0.
  typedef struct packed {
    logic [JSU_CNT_W-1:0]             cnt;
    logic [JSU_MAX_OUT-1:0][7:0]      bytes;
  } jsu_res_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;

endpackage

`default_nettype wire

// ----- hdl/jsu_decode.sv -----
// Decode of one raw byte against the escape state: next state and result bytes.
`default_nettype none

module jsu_decode (
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  input  logic               last_i,
  input  jsu_pkg::jsu_state_t st_i,
  output jsu_pkg::jsu_state_t st_o,
  output jsu_pkg::jsu_res_t   res_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_BYTE = 2'd1,
    EMIT_UTF8 = 2'd2
  } jsu_emit_t;

  jsu_state_t  eff;
  logic        open_quote;
  logic        drop_close;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [15:0] hv_new;
  logic        he_new;
  logic [7:0]  esc_val;
  jsu_emit_t   emit;
  logic [7:0]  emit_byte;

  function automatic jsu_res_t utf8_enc(input logic [15:0] v);
    jsu_res_t r;
    r = '0;
    if (v < UTF8_LIM1) begin
      r.cnt      = JSU_CNT_W'(1);
      r.bytes[0] = v[7:0];
    end else if (v < UTF8_LIM2) begin
      r.cnt      = JSU_CNT_W'(2);
      r.bytes[0] = UTF8_LEAD2 | {3'b000, v[10:6]};
      r.bytes[1] = UTF8_CONT | {2'b00, v[5:0]};
    end else begin
      r.cnt      = JSU_CNT_W'(3);
      r.bytes[0] = UTF8_LEAD3 | {4'b0000, v[15:12]};
      r.bytes[1] = UTF8_CONT | {2'b00, v[11:6]};
      r.bytes[2] = UTF8_CONT | {2'b00, v[5:0]};
    end
    return r;
  endfunction

  // A span start abandons any pending escape.
  assign eff        = first_i ? JSU_STATE_RST : st_i;
  assign open_quote = first_i && (byte_i == CH_QUOTE);
  assign drop_close = last_i && eff.quoted && (eff.mode == MODE_PLAIN);

  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'h0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      dig_val = byte_i[3:0];
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h46) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h66)) begin
      dig_val = byte_i[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign hv_new = (!eff.hex_ended && dig_ok) ? {eff.hex_value[11:0], dig_val}
                                             : eff.hex_value;
  assign he_new = eff.hex_ended | ~dig_ok;

  always_comb begin
    case (byte_i)
      CH_B:    esc_val = 8'h08;
      CH_F:    esc_val = 8'h0C;
      CH_N:    esc_val = 8'h0A;
      CH_R:    esc_val = 8'h0D;
      CH_T:    esc_val = 8'h09;
      default: esc_val = byte_i;
    endcase
  end

  // Next state.
  always_comb begin
    st_o = eff;
    if (open_quote) begin
      st_o        = JSU_STATE_RST;
      st_o.quoted = ~last_i;
    end else begin
      if (!drop_close) begin
        case (eff.mode)
          MODE_ESC: begin
            if (byte_i == CH_U) begin
              st_o.mode      = MODE_HEX1;
              st_o.hex_value = 16'h0000;
              st_o.hex_ended = 1'b0;
            end else begin
              st_o.mode = MODE_PLAIN;
            end
          end
          MODE_HEX1: begin
            st_o.mode      = MODE_HEX2;
            st_o.hex_value = hv_new;
            st_o.hex_ended = he_new;
          end
          MODE_HEX2: begin
            st_o.mode      = MODE_HEX3;
            st_o.hex_value = hv_new;
            st_o.hex_ended = he_new;
          end
          MODE_HEX3: begin
            st_o.mode      = MODE_HEX4;
            st_o.hex_value = hv_new;
            st_o.hex_ended = he_new;
          end
          MODE_HEX4: begin
            st_o.mode      = MODE_PLAIN;
            st_o.hex_value = hv_new;
            st_o.hex_ended = he_new;
          end
          default: begin
            st_o.mode = (byte_i == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
          end
        endcase
      end
      if (last_i) begin
        st_o = JSU_STATE_RST;
      end
    end
  end

  // Result selection; a cut-short unicode escape flushes on the span's last byte.
  always_comb begin
    emit      = EMIT_NONE;
    emit_byte = byte_i;
    if (!open_quote && !drop_close) begin
      case (eff.mode)
        MODE_ESC: begin
          if (byte_i != CH_U) begin
            emit      = EMIT_BYTE;
            emit_byte = esc_val;
          end else if (last_i) begin
            emit = EMIT_UTF8;
          end
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          if (last_i) begin
            emit = EMIT_UTF8;
          end
        end
        MODE_HEX4: emit = EMIT_UTF8;
        default: begin
          if (byte_i != CH_BSLASH) begin
            emit = EMIT_BYTE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    case (emit)
      EMIT_BYTE: begin
        res_o.cnt      = JSU_CNT_W'(1);
        res_o.bytes[0] = emit_byte;
      end
      EMIT_UTF8: begin
        // After a bare backslash-u the collected value is zero.
        res_o = utf8_enc((eff.mode == MODE_ESC) ? 16'h0000 : hv_new);
      end
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/jsu_obuf.sv -----
// Result buffer: holds up to three bytes of one input byte and drains one per cycle while out_tready is high.
`default_nettype none

module jsu_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::jsu_res_t res,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import jsu_pkg::*;

  logic [JSU_CNT_W-1:0]        rem_r, rem_nxt;
  logic [JSU_MAX_OUT-1:0][7:0] bytes_r, bytes_nxt;
  logic                        fire;

  assign fire       = out_tvalid && out_tready;
  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = (rem_r == JSU_CNT_W'(1));
  assign free       = (rem_r == '0) || (out_tlast && out_tready);

  always_comb begin
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (load) begin
      rem_nxt   = res.cnt;
      bytes_nxt = res.bytes;
    end else if (fire) begin
      rem_nxt = rem_r - JSU_CNT_W'(1);
      for (int i = 0; i < JSU_MAX_OUT - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescaper with UTF-8 output of unicode escapes.
//
//  channel | dir | payload                                  | handshake
//  in_     | in  | tdata[7:0] in_byte, tuser[0] span_first,  | in_tvalid / in_tready
//          |     | tlast span_last                          |
//  out_    | out | tdata[7:0] out_byte, tlast run_end       | out_tvalid / out_tready
//
// One raw byte is accepted per cycle while in_tready is high. It is held in the
// input register, then is decoded in a single pass into zero to three result
// bytes that load the result buffer, from which the first result reaches the port.
// The output port moves one byte per cycle while out_tready is high, so a unicode
// escape that expands to two or three bytes holds the input side while they drain.
// Reset (rst_n low, synchronous) clears the escape state and both valid stages.
// A stall on out_tready holds the buffer, then the input register, then in_tready.
`default_nettype none

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] span_first
  input  logic       in_tlast,   // span_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_end
);
  import jsu_pkg::*;

  // Input register.
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       last_r;
  logic       in_fire;

  // Escape state carried from byte to byte.
  jsu_state_t st_r, st_nxt;
  jsu_state_t st_dec;
  jsu_res_t   res_dec;

  logic buf_free;
  logic proc;

  // Advance the decoded byte whenever the result buffer is empty or empties this cycle.
  assign proc      = in_v_r && buf_free;
  assign in_tready = !in_v_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  assign in_v_nxt = in_fire ? 1'b1 : (proc ? 1'b0 : in_v_r);
  assign st_nxt   = proc ? st_dec : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= JSU_STATE_RST;
    end else begin
      in_v_r <= in_v_nxt;
      st_r   <= st_nxt;
    end
  end

  // Payload of the input register: load on each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser[0];
      last_r  <= in_tlast;
    end
  end

  jsu_decode u_decode (
    .byte_i  (byte_r),
    .first_i (first_r),
    .last_i  (last_r),
    .st_i    (st_r),
    .st_o    (st_dec),
    .res_o   (res_dec)
  );

  // An item with no result loads an empty buffer and simply drops out.
  jsu_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (proc),
    .res        (res_dec),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/jsu_checker.sv -----
// Port-level checker for the JSON string unescaper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Count result bytes since the last run end.
  logic [1:0] run_cnt_r, run_cnt_nxt;
  logic       out_fire;

  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    run_cnt_nxt = run_cnt_r;
    if (out_fire) begin
      run_cnt_nxt = out_tlast ? 2'd0 : run_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= 2'd0;
    end else begin
      run_cnt_r <= run_cnt_nxt;
    end
  end

  `JSU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result transaction changed")
  `JSU_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")
  `JSU_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid, "input held while no result pending")
  `JSU_ASSERT(a_run_len, clk, rst_n, out_fire && !out_tlast |-> run_cnt_r != 2'd2, "more than three result bytes in one run")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- tb/json_string_unescape_utf8_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the JSON string unescaper: directed and random spans.
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
  } out_byte_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic [0:0] in_tuser   = 1'b0;   // [0] span_first
  logic       in_tlast   = 1'b0;   // span_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;           // run_end

  json_string_unescape_utf8 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decoder state mirrored from the block.
  jsu_mode_t   esc_mode    = MODE_PLAIN;
  logic [15:0] hex_acc     = 16'h0000;
  logic        hex_stop    = 1'b0;
  logic        quoted_span = 1'b0;

  out_byte_t  unescaped_q[$];   // bytes still owed by the block, oldest first
  logic [7:0] step_bytes[$];    // bytes caused by the current input byte

  int errors      = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit in_gaps_en    = 1'b1;
  bit out_stalls_en = 1'b1;

  // Mostly short gaps, a few long ones.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_decoder();
    esc_mode    = MODE_PLAIN;
    hex_acc     = 16'h0000;
    hex_stop    = 1'b0;
    quoted_span = 1'b0;
  endtask

  // Encode a code point as 1 to 3 UTF-8 bytes, lead byte first.
  task automatic push_utf8(input logic [15:0] v);
    if (v < UTF8_LIM1) begin
      step_bytes.push_back(v[7:0]);
    end else if (v < UTF8_LIM2) begin
      step_bytes.push_back(UTF8_LEAD2 | {3'b000, v[10:6]});
      step_bytes.push_back(UTF8_CONT | {2'b00, v[5:0]});
    end else begin
      step_bytes.push_back(UTF8_LEAD3 | {4'b0000, v[15:12]});
      step_bytes.push_back(UTF8_CONT | {2'b00, v[11:6]});
      step_bytes.push_back(UTF8_CONT | {2'b00, v[5:0]});
    end
  endtask

  task automatic predict_unescape(input logic [7:0] b, input logic first, input logic last);
    int digit;
    step_bytes.delete();
    if (first) begin
      clear_decoder();
      // An opening quote is swallowed; a lone quote opens nothing.
      if (b == CH_QUOTE) begin
        quoted_span = !last;
        return;
      end
    end

    if (last && quoted_span && esc_mode == MODE_PLAIN) begin
      // drop the closing quote
    end else if (esc_mode == MODE_ESC) begin
      if (b == CH_U) begin
        esc_mode = MODE_HEX1;
        hex_acc  = 16'h0000;
        hex_stop = 1'b0;
      end else begin
        case (b)
          CH_B:    step_bytes.push_back(8'h08);
          CH_F:    step_bytes.push_back(8'h0C);
          CH_N:    step_bytes.push_back(8'h0A);
          CH_R:    step_bytes.push_back(8'h0D);
          CH_T:    step_bytes.push_back(8'h09);
          default: step_bytes.push_back(b);
        endcase
        esc_mode = MODE_PLAIN;
      end
    end else if (esc_mode >= MODE_HEX1 && esc_mode <= MODE_HEX4) begin
      if (b >= 8'h30 && b <= 8'h39)      digit = b - 8'h30;
      else if (b >= 8'h41 && b <= 8'h46) digit = b - 8'h41 + 10;
      else if (b >= 8'h61 && b <= 8'h66) digit = b - 8'h61 + 10;
      else                               digit = -1;
      // The first non-hex byte freezes the value for the rest of the escape.
      if (!hex_stop && digit >= 0) hex_acc = {hex_acc[11:0], digit[3:0]};
      else hex_stop = 1'b1;
      if (esc_mode == MODE_HEX4) begin
        push_utf8(hex_acc);
        esc_mode = MODE_PLAIN;
      end else begin
        esc_mode = jsu_mode_t'(esc_mode + 3'd1);
      end
    end else begin
      if (b == CH_BSLASH) begin
        esc_mode = MODE_ESC;
      end else begin
        esc_mode = MODE_PLAIN;
        step_bytes.push_back(b);
      end
    end

    if (last) begin
      // A unicode escape cut short by the span end is flushed now.
      if (esc_mode >= MODE_HEX1 && esc_mode <= MODE_HEX4) push_utf8(hex_acc);
      clear_decoder();
    end

    foreach (step_bytes[i])
      unescaped_q.push_back('{data: step_bytes[i], run_end: (i == step_bytes.size() - 1)});
  endtask

  // Score results, predict accepted bytes and watch for a hang.
  always @(posedge clk) begin
    out_byte_t exp_b;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (unescaped_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual byte %02h run_end %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          exp_b = unescaped_q.pop_front();
          if (out_tdata !== exp_b.data) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, exp_b.data, out_tdata);
          end
          if (out_tlast !== exp_b.run_end) begin
            errors++;
            $display("%0t: run_end mismatch, expected %0b, actual %0b",
                     $time, exp_b.run_end, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) predict_unescape(in_tdata, in_tuser[0], in_tlast);
    end

    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver backpressure: random stalls when enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (out_stalls_en && $urandom_range(0, 99) < 25) begin
      stall_left = rand_gap();
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Present one byte, hold it until the transaction, then idle for a random gap if gaps are enabled.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = first;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    gap = in_gaps_en ? rand_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = 8'($urandom);
      in_tuser  = 1'($urandom);
      in_tlast  = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_span(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0, i == s.len() - 1);
  endtask

  task automatic test_quoted_spans();
    send_span("\"\\t\\\"");        // tab, then an escape open at the closing quote
    send_byte(CH_QUOTE, 1'b1, 1'b1); // lone quote with both marks
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h41, 1'b0, 1'b0);    // byte outside any span
    send_span("a\\");              // backslash as the last byte
  endtask

  task automatic test_escapes();
    send_span("\\n\\r\\q");
    send_byte(CH_BSLASH, 1'b1, 1'b0); // pending escape abandoned by a new span
    send_byte(8'h78, 1'b1, 1'b1);
  endtask

  task automatic test_unicode_escapes();
    send_span("\"\\u00e9\"");  // two-byte UTF-8
    send_span("\\uD83");       // cut short, three-byte UTF-8
    send_span("\\uz");         // no digits and cut short
    send_span("\\uFFFF");      // largest value
  endtask

  // Mostly well-formed spans with random content, some cut short, some noise.
  task automatic test_random_traffic(input int n_bytes);
    logic [7:0] span_q[$];
    string      hex_chars;
    int         kind, cut, lead, sent;
    bit         quoted, no_last;
    hex_chars = "0123456789abcdefABCDEF";
    sent = 0;
    while (sent < n_bytes) begin
      span_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
          sent++;
        end
        continue;
      end
      quoted = (kind < 80);
      if (quoted) span_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 5))
          0, 1: span_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
          2: span_q.push_back(8'($urandom));
          3: begin
            span_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 8))
              0: span_q.push_back(CH_B);
              1: span_q.push_back(CH_F);
              2: span_q.push_back(CH_N);
              3: span_q.push_back(CH_R);
              4: span_q.push_back(CH_T);
              5: span_q.push_back(CH_QUOTE);
              6: span_q.push_back(CH_BSLASH);
              7: span_q.push_back(8'h2F);  // solidus
              default: span_q.push_back(8'($urandom));
            endcase
          end
          4: begin
            // Leading zeros bias some escapes into the one- and two-byte ranges.
            span_q.push_back(CH_BSLASH);
            span_q.push_back(CH_U);
            lead = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
              span_q.push_back(k < lead ? 8'h30 : hex_chars[$urandom_range(0, 21)]);
          end
          default: begin
            span_q.push_back(CH_BSLASH);
            span_q.push_back(CH_U);
            repeat (4)
              span_q.push_back($urandom_range(0, 2) == 0 ? 8'($urandom)
                                                          : hex_chars[$urandom_range(0, 21)]);
          end
        endcase
      end
      if (quoted) span_q.push_back(CH_QUOTE);
      if (span_q.size() == 0) span_q.push_back(8'($urandom));

      cut = span_q.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, span_q.size());
      no_last = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < cut; i++) begin
        send_byte(span_q[i], i == 0, !no_last && i == cut - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_quoted_spans();
    test_escapes();
    test_unicode_escapes();

    in_gaps_en = 1'b1; out_stalls_en = 1'b1;
    test_random_traffic(85);
    in_gaps_en = 1'b0; out_stalls_en = 1'b0;
    test_random_traffic(50);
    in_gaps_en = 1'b1; out_stalls_en = 1'b0;
    test_random_traffic(25);
    in_gaps_en = 1'b0; out_stalls_en = 1'b1;
    test_random_traffic(25);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (unescaped_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_obuf.sv
hdl/json_string_unescape_utf8.sv
hdl/jsu_checker.sv
tb/json_string_unescape_utf8_tb.sv
